FILE: rtl/ssa_pkg.sv
package ssa_pkg;

  localparam int NUM_FRAMES = 64;
  localparam int SLOTS      = 32;
  localparam int FRAME_W    = 6;
  localparam int SLOT_W     = 5;
  localparam int FREE_W     = 6;
  localparam int TOTAL_W    = 7;
  localparam int FS_AW      = FRAME_W + SLOT_W;

  localparam logic [FREE_W-1:0] FULL_COUNT = 6'd32;
  localparam logic [SLOT_W-1:0] LAST_SLOT  = 5'd31;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_RETURN = 2'd1,
    OP_TRIM   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic {
    ST_DONE = 1'b0,
    ST_FULL = 1'b1
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_A_MAP, S_A_CNT, S_A_POP, S_A_SLOT, S_O_SCAN, S_O_FILL,
    S_R_CNT, S_R_MAP, S_T_MAP, S_T_CNT, S_T_CHK, S_T_MOVE, S_RSCAN, S_DONE
  } state_t;

  typedef struct packed {
    op_t                operation;
    logic [FRAME_W-1:0] frame_in;
    logic [SLOT_W-1:0]  slot_in;
  } in_item_t;

  typedef struct packed {
    logic               status;
    logic [FRAME_W-1:0] frame_out;
    logic [SLOT_W-1:0]  slot_out;
    logic [TOTAL_W-1:0] slabs_in_use;
  } out_item_t;

  typedef struct packed {
    logic              we;
    logic [FS_AW-1:0]  waddr;
    logic [SLOT_W-1:0] wdata;
    logic [FS_AW-1:0]  raddr;
  } fs_req_t;

  typedef struct packed {
    logic               we;
    logic [FRAME_W-1:0] waddr;
    logic [FRAME_W-1:0] wdata;
    logic [FRAME_W-1:0] raddr;
  } tab_req_t;

endpackage

FILE: rtl/ssa_ram.sv
module ssa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/ssa_ctrl.sv
module ssa_ctrl
  import ssa_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  in_item_t           in_item,
  output logic               in_busy,
  input  logic               out_free,
  output logic               res_valid,
  output out_item_t          res_item,
  output fs_req_t            fs_req,
  input  logic [SLOT_W-1:0]  fs_rd,
  output tab_req_t           fc_req,
  input  logic [FREE_W-1:0]  fc_rd,
  output tab_req_t           l2f_req,
  input  logic [FRAME_W-1:0] l2f_rd,
  output tab_req_t           f2l_req,
  input  logic [FRAME_W-1:0] f2l_rd
);

  state_t              state_r, state_nxt;
  logic [NUM_FRAMES-1:0] busy_r, busy_nxt;
  logic [TOTAL_W-1:0]  total_r, total_nxt;
  logic                hint_v_r, hint_v_nxt;
  logic [FRAME_W-1:0]  hint_r, hint_nxt;
  logic [TOTAL_W-1:0]  idx_r, idx_nxt;
  logic                v1_r, v1_nxt, v2_r, v2_nxt;
  logic [FRAME_W-1:0]  i1_r, i1_nxt, i2_r, i2_nxt;
  logic [FRAME_W-1:0]  f_r, f_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic [SLOT_W-1:0]   cnt_r, cnt_nxt;
  logic [SLOT_W-1:0]   fill_r, fill_nxt;
  logic                res_stat_r, res_stat_nxt;
  logic [FRAME_W-1:0]  res_frame_r, res_frame_nxt;
  logic [SLOT_W-1:0]   res_slot_r, res_slot_nxt;

  logic               hint_ok, scan_fail, scan_hit, rs_hit, rs_end;
  logic [FREE_W-1:0]  fc_dec, fc_inc;
  logic [TOTAL_W-1:0] total_dec;

  assign hint_ok   = hint_v_r && ({1'b0, hint_r} < total_r);
  assign scan_fail = total_r[TOTAL_W-1] || idx_r[TOTAL_W-1];
  assign scan_hit  = !scan_fail && !busy_r[idx_r[FRAME_W-1:0]];
  assign rs_hit    = v2_r && (fc_rd != '0);
  assign rs_end    = !v1_r && !v2_r && (idx_r >= total_r);
  assign fc_dec    = fc_rd - 6'd1;
  assign fc_inc    = fc_rd + 6'd1;
  assign total_dec = total_r - 7'd1;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_item.operation)
            OP_ALLOC:  state_nxt = hint_ok ? S_A_MAP : S_O_SCAN;
            OP_RETURN: state_nxt = busy_r[in_item.frame_in] ? S_R_CNT : S_DONE;
            OP_TRIM:   state_nxt = S_T_MAP;
            default:   state_nxt = S_DONE;
          endcase
        end
      end
      S_A_MAP:  state_nxt = S_A_CNT;
      S_A_CNT:  state_nxt = (fc_rd == '0) ? S_O_SCAN : S_A_POP;
      S_O_SCAN: begin
        if (scan_fail) begin
          state_nxt = S_DONE;
        end else if (scan_hit) begin
          state_nxt = S_O_FILL;
        end
      end
      S_O_FILL: state_nxt = (fill_r == LAST_SLOT) ? S_A_POP : S_O_FILL;
      S_A_POP:  state_nxt = S_A_SLOT;
      S_A_SLOT: state_nxt = (cnt_r == '0) ? S_RSCAN : S_DONE;
      S_R_CNT:  state_nxt = fc_rd[FREE_W-1] ? S_DONE : S_R_MAP;
      S_R_MAP:  state_nxt = S_DONE;
      S_T_MAP:  state_nxt = (idx_r >= total_r) ? S_RSCAN : S_T_CNT;
      S_T_CNT:  state_nxt = S_T_CHK;
      S_T_CHK:  state_nxt = (fc_rd == FULL_COUNT) ? S_T_MOVE : S_T_MAP;
      S_T_MOVE: state_nxt = S_T_MAP;
      S_RSCAN:  state_nxt = (rs_hit || rs_end) ? S_DONE : S_RSCAN;
      S_DONE:   state_nxt = out_free ? S_IDLE : S_DONE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory commands
  always_comb begin
    busy_nxt      = busy_r;
    total_nxt     = total_r;
    hint_v_nxt    = hint_v_r;
    hint_nxt      = hint_r;
    idx_nxt       = idx_r;
    v1_nxt        = 1'b0;
    v2_nxt        = 1'b0;
    i1_nxt        = i1_r;
    i2_nxt        = i2_r;
    f_nxt         = f_r;
    slot_nxt      = slot_r;
    cnt_nxt       = cnt_r;
    fill_nxt      = fill_r;
    res_stat_nxt  = res_stat_r;
    res_frame_nxt = res_frame_r;
    res_slot_nxt  = res_slot_r;
    fs_req        = '0;
    fc_req        = '0;
    l2f_req       = '0;
    f2l_req       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          res_stat_nxt  = ST_DONE;
          res_frame_nxt = '0;
          res_slot_nxt  = '0;
          f_nxt         = in_item.frame_in;
          slot_nxt      = in_item.slot_in;
          idx_nxt       = '0;
          case (in_item.operation)
            OP_ALLOC: begin
              if (hint_ok) begin
                l2f_req.raddr = hint_r;
              end else begin
                hint_v_nxt = 1'b0;
              end
            end
            OP_RETURN: fc_req.raddr = in_item.frame_in;
            default: ;
          endcase
        end
      end
      S_A_MAP: begin
        f_nxt        = l2f_rd;
        fc_req.raddr = l2f_rd;
      end
      S_A_CNT: begin
        if (fc_rd == '0) begin
          hint_v_nxt = 1'b0;
        end else begin
          cnt_nxt = fc_dec[SLOT_W-1:0];
        end
      end
      S_O_SCAN: begin
        if (scan_fail) begin
          res_stat_nxt = ST_FULL;
        end else if (scan_hit) begin
          f_nxt                         = idx_r[FRAME_W-1:0];
          busy_nxt[idx_r[FRAME_W-1:0]]  = 1'b1;
          l2f_req.we                    = 1'b1;
          l2f_req.waddr                 = total_r[FRAME_W-1:0];
          l2f_req.wdata                 = idx_r[FRAME_W-1:0];
          f2l_req.we                    = 1'b1;
          f2l_req.waddr                 = idx_r[FRAME_W-1:0];
          f2l_req.wdata                 = total_r[FRAME_W-1:0];
          hint_v_nxt                    = 1'b1;
          hint_nxt                      = total_r[FRAME_W-1:0];
          total_nxt                     = total_r + 7'd1;
          fill_nxt                      = '0;
        end else begin
          idx_nxt = idx_r + 7'd1;
        end
      end
      S_O_FILL: begin
        // stack positions 0..31 hold 31..0 so slot 0 pops first
        fs_req.we    = 1'b1;
        fs_req.waddr = {f_r, fill_r};
        fs_req.wdata = ~fill_r;
        fill_nxt     = fill_r + 5'd1;
        cnt_nxt      = LAST_SLOT;
      end
      S_A_POP: begin
        fc_req.we    = 1'b1;
        fc_req.waddr = f_r;
        fc_req.wdata = {1'b0, cnt_r};
        fs_req.raddr = {f_r, cnt_r};
      end
      S_A_SLOT: begin
        res_frame_nxt = f_r;
        res_slot_nxt  = fs_rd;
        if (cnt_r == '0) begin
          hint_v_nxt = 1'b0;
          hint_nxt   = '0;
          idx_nxt    = {1'b0, hint_r} + 7'd1;
        end
      end
      S_R_CNT: begin
        if (!fc_rd[FREE_W-1]) begin
          fs_req.we     = 1'b1;
          fs_req.waddr  = {f_r, fc_rd[SLOT_W-1:0]};
          fs_req.wdata  = slot_r;
          fc_req.we     = 1'b1;
          fc_req.waddr  = f_r;
          fc_req.wdata  = fc_inc;
          f2l_req.raddr = f_r;
        end
      end
      S_R_MAP: begin
        if (!hint_v_r || (f2l_rd < hint_r)) begin
          hint_v_nxt = 1'b1;
          hint_nxt   = f2l_rd;
        end
      end
      S_T_MAP: begin
        if (idx_r >= total_r) begin
          hint_v_nxt = 1'b0;
          hint_nxt   = '0;
          idx_nxt    = '0;
        end else begin
          l2f_req.raddr = idx_r[FRAME_W-1:0];
        end
      end
      S_T_CNT: begin
        f_nxt        = l2f_rd;
        fc_req.raddr = l2f_rd;
      end
      S_T_CHK: begin
        if (fc_rd != FULL_COUNT) begin
          idx_nxt = idx_r + 7'd1;
        end else begin
          busy_nxt[f_r] = 1'b0;
          total_nxt     = total_dec;
          l2f_req.raddr = total_dec[FRAME_W-1:0];
        end
      end
      S_T_MOVE: begin
        // move the last slab into the hole
        l2f_req.we    = 1'b1;
        l2f_req.waddr = idx_r[FRAME_W-1:0];
        l2f_req.wdata = l2f_rd;
        if (idx_r < total_r) begin
          f2l_req.we    = 1'b1;
          f2l_req.waddr = l2f_rd;
          f2l_req.wdata = idx_r[FRAME_W-1:0];
        end
      end
      S_RSCAN: begin
        if (idx_r < total_r) begin
          l2f_req.raddr = idx_r[FRAME_W-1:0];
          v1_nxt        = 1'b1;
          i1_nxt        = idx_r[FRAME_W-1:0];
          idx_nxt       = idx_r + 7'd1;
        end
        v2_nxt       = v1_r;
        i2_nxt       = i1_r;
        fc_req.raddr = l2f_rd;
        if (rs_hit) begin
          hint_v_nxt = 1'b1;
          hint_nxt   = i2_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      busy_r   <= '0;
      total_r  <= '0;
      hint_v_r <= 1'b0;
      hint_r   <= '0;
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      busy_r   <= busy_nxt;
      total_r  <= total_nxt;
      hint_v_r <= hint_v_nxt;
      hint_r   <= hint_nxt;
      v1_r     <= v1_nxt;
      v2_r     <= v2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    i1_r        <= i1_nxt;
    i2_r        <= i2_nxt;
    f_r         <= f_nxt;
    slot_r      <= slot_nxt;
    cnt_r       <= cnt_nxt;
    fill_r      <= fill_nxt;
    res_stat_r  <= res_stat_nxt;
    res_frame_r <= res_frame_nxt;
    res_slot_r  <= res_slot_nxt;
  end

  assign in_busy                = (state_r != S_IDLE);
  assign res_valid              = (state_r == S_DONE);
  assign res_item.status        = res_stat_r;
  assign res_item.frame_out     = res_frame_r;
  assign res_item.slot_out      = res_slot_r;
  assign res_item.slabs_in_use  = total_r;

`ifndef NO_ASSERTIONS
  a_busy_matches_total: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> ($countones(busy_r) == int'(total_r)))
    else $error("busy frame count differs from live slab total");

  a_hint_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && hint_v_r) |-> ({1'b0, hint_r} < total_r))
    else $error("hint points past the live slab list");

  a_fill_busy_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_O_FILL) |-> busy_r[f_r])
    else $error("filling a frame that is not marked busy");
`endif

endmodule

FILE: rtl/slab_slot_allocator_core.sv
// Slab slot allocator: hands out slots in frames of 32, one result item per
// input item (allocate, return or trim). Free slot stacks, free counts and the
// logical/physical slab maps live in synchronous RAMs; the controller walks
// them through a state machine, so an item takes a variable number of cycles.
// Allocate from a hinted slab pops one slot; opening a new slab adds a
// busy-frame scan and a fill of all 32 stack entries; emptying a slab adds a
// hint rescan. Trim visits every live slab, frees each full one, and then
// rescans the hint. The block takes one item at a time, accepting while the
// previous result still waits in the output register.
module slab_slot_allocator_core
  import ssa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  fs_req_t            fs_req;
  tab_req_t           fc_req, l2f_req, f2l_req;
  logic [SLOT_W-1:0]  fs_rd;
  logic [FREE_W-1:0]  fc_rd;
  logic [FRAME_W-1:0] l2f_rd, f2l_rd;
  logic               in_busy, res_valid, out_free;
  out_item_t          res_item;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_item_r, out_item_nxt;

  // free slot stacks, one row of 32 per frame
  ssa_ram #(.WIDTH(SLOT_W), .DEPTH(NUM_FRAMES * SLOTS)) u_free_stack (
    .clk   (clk),
    .we    (fs_req.we),
    .waddr (fs_req.waddr),
    .wdata (fs_req.wdata),
    .raddr (fs_req.raddr),
    .rdata (fs_rd)
  );

  ssa_ram #(.WIDTH(FREE_W), .DEPTH(NUM_FRAMES)) u_free_counts (
    .clk   (clk),
    .we    (fc_req.we),
    .waddr (fc_req.waddr),
    .wdata (fc_req.wdata[FREE_W-1:0]),
    .raddr (fc_req.raddr),
    .rdata (fc_rd)
  );

  ssa_ram #(.WIDTH(FRAME_W), .DEPTH(NUM_FRAMES)) u_logical_to_frame (
    .clk   (clk),
    .we    (l2f_req.we),
    .waddr (l2f_req.waddr),
    .wdata (l2f_req.wdata),
    .raddr (l2f_req.raddr),
    .rdata (l2f_rd)
  );

  ssa_ram #(.WIDTH(FRAME_W), .DEPTH(NUM_FRAMES)) u_frame_to_logical (
    .clk   (clk),
    .we    (f2l_req.we),
    .waddr (f2l_req.waddr),
    .wdata (f2l_req.wdata),
    .raddr (f2l_req.raddr),
    .rdata (f2l_rd)
  );

  ssa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .in_busy   (in_busy),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res_item  (res_item),
    .fs_req    (fs_req),
    .fs_rd     (fs_rd),
    .fc_req    (fc_req),
    .fc_rd     (fc_rd),
    .l2f_req   (l2f_req),
    .l2f_rd    (l2f_rd),
    .f2l_req   (f2l_req),
    .f2l_rd    (f2l_rd)
  );

  // output register: free when empty or being taken this cycle
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (res_valid && out_free) begin
      out_valid_nxt = 1'b1;
      out_item_nxt  = res_item;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign in_stall  = in_busy;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

FILE: tb/slab_slot_allocator_core_test.sv
`timescale 1ns / 100ps

module slab_slot_allocator_core_test;
  import ssa_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  slab_slot_allocator_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  // Shadow copy of the allocator state, kept by the slot predictor.
  logic [SLOT_W-1:0]  shadow_stack [NUM_FRAMES][SLOTS];
  int unsigned        shadow_count [NUM_FRAMES];
  int unsigned        shadow_l2f   [NUM_FRAMES];
  int unsigned        shadow_f2l   [NUM_FRAMES];
  bit                 shadow_busy  [NUM_FRAMES];
  int unsigned        shadow_live;
  bit                 shadow_hint_ok;
  int unsigned        shadow_hint;

  out_item_t   expected_items[$];
  int          error_count;
  int          items_sent;
  int          items_checked;
  int          alloc_full_seen;
  int          trims_seen;
  bit          quiet_mode;
  bit          hold_off;
  int          idle_cycles;

  // Slots handed out and not yet returned, kept as {frame, slot}.
  logic [FS_AW-1:0] held_slots[$];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    $display("ERROR t=%0t item %0d: %s got %0d want %0d", $realtime, items_checked, what,
             got, want);
  endtask

  // Find the lowest logical slab at or after start that still has room.
  function automatic void rescan_hint(input int unsigned start);
    shadow_hint_ok = 1'b0;
    shadow_hint    = 0;
    for (int unsigned i = start; i < shadow_live && i < NUM_FRAMES; i++) begin
      if (shadow_count[shadow_l2f[i]] != 0) begin
        shadow_hint_ok = 1'b1;
        shadow_hint    = i;
        return;
      end
    end
  endfunction

  function automatic bit open_new_slab();
    int f;
    if (shadow_live >= NUM_FRAMES) return 1'b0;
    for (f = 0; f < NUM_FRAMES; f++) if (!shadow_busy[f]) break;
    if (f >= NUM_FRAMES) return 1'b0;
    shadow_count[f] = SLOTS;
    for (int i = 0; i < SLOTS; i++) shadow_stack[f][i] = SLOT_W'(SLOTS - 1 - i);
    shadow_busy[f]          = 1'b1;
    shadow_l2f[shadow_live] = f;
    shadow_f2l[f]           = shadow_live;
    shadow_hint_ok          = 1'b1;
    shadow_hint             = shadow_live;
    shadow_live++;
    return 1'b1;
  endfunction

  // Compute the result item of one accepted input item and advance the shadow.
  function automatic out_item_t predict_slot_result(input in_item_t it);
    out_item_t   r;
    int unsigned f;
    int unsigned cnt;
    r = '0;
    case (it.operation)
      OP_ALLOC: begin
        if (shadow_hint_ok && (shadow_hint >= shadow_live ||
            shadow_count[shadow_l2f[shadow_hint % NUM_FRAMES]] == 0))
          shadow_hint_ok = 1'b0;
        if (!shadow_hint_ok && !open_new_slab()) begin
          r.status = ST_FULL;
        end else begin
          f   = shadow_l2f[shadow_hint % NUM_FRAMES];
          cnt = shadow_count[f] - 1;
          shadow_count[f] = cnt;
          r.frame_out = f[FRAME_W-1:0];
          r.slot_out  = shadow_stack[f][cnt % SLOTS];
          if (cnt == 0) rescan_hint(shadow_hint + 1);
        end
      end
      OP_RETURN: begin
        f = it.frame_in;
        if (shadow_busy[f] && shadow_count[f] < SLOTS) begin
          cnt = shadow_count[f];
          shadow_stack[f][cnt] = it.slot_in;
          shadow_count[f]      = cnt + 1;
          if (!shadow_hint_ok || shadow_f2l[f] < shadow_hint) begin
            shadow_hint_ok = 1'b1;
            shadow_hint    = shadow_f2l[f];
          end
        end
      end
      OP_TRIM: begin
        int unsigned idx;
        idx = 0;
        while (idx < shadow_live) begin
          f = shadow_l2f[idx];
          if (shadow_count[f] != SLOTS) begin
            idx++;
            continue;
          end
          shadow_busy[f] = 1'b0;
          shadow_live--;
          shadow_l2f[idx] = shadow_l2f[shadow_live];
          if (idx < shadow_live) shadow_f2l[shadow_l2f[idx]] = idx;
        end
        rescan_hint(0);
      end
      default: ;
    endcase
    r.slabs_in_use = shadow_live[TOTAL_W-1:0];
    return r;
  endfunction

  // Track slots held by the stimulus so returns mostly hit live slots.
  function automatic void note_result(input in_item_t it, input out_item_t r);
    if (it.operation == OP_ALLOC && r.status == ST_DONE)
      held_slots.push_back({r.frame_out, r.slot_out});
  endfunction

  // Send one item: drive at the rising edge, hold until accepted, then drop valid
  // (the block stalls its input after any accept).
  task automatic send_item(input in_item_t it);
    out_item_t r;
    while (!quiet_mode && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = predict_slot_result(it);
    note_result(it, r);
    expected_items.push_back(r);
    items_sent++;
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_op(input op_t op, input int frame, input int slot);
    in_item_t it;
    it.operation = op;
    it.frame_in  = frame[FRAME_W-1:0];
    it.slot_in   = slot[SLOT_W-1:0];
    send_item(it);
  endtask

  // Return a random held slot, or a random slot when none is held; remove it from the held list.
  task automatic return_held();
    int k;
    logic [FS_AW-1:0] fs;
    if (held_slots.size() == 0) begin
      send_op(OP_RETURN, $urandom_range(63), $urandom_range(31));
      return;
    end
    k  = $urandom_range(held_slots.size() - 1);
    fs = held_slots[k];
    held_slots.delete(k);
    send_op(OP_RETURN, fs[FS_AW-1:SLOT_W], fs[SLOT_W-1:0]);
  endtask

  task automatic wait_drained();
    while (expected_items.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // Check each accepted result against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_items.size() == 0) begin
        report_mismatch("unexpected result, slabs_in_use", out_item.slabs_in_use, -1);
      end else begin
        out_item_t e;
        e = expected_items.pop_front();
        if (out_item.status !== e.status)
          report_mismatch("status", out_item.status, e.status);
        if (out_item.frame_out !== e.frame_out)
          report_mismatch("frame_out", out_item.frame_out, e.frame_out);
        if (out_item.slot_out !== e.slot_out)
          report_mismatch("slot_out", out_item.slot_out, e.slot_out);
        if (out_item.slabs_in_use !== e.slabs_in_use)
          report_mismatch("slabs_in_use", out_item.slabs_in_use, e.slabs_in_use);
        if (e.status == ST_FULL) alloc_full_seen++;
      end
      items_checked++;
    end
  end

  // Receiver stall: random, none in quiet mode, solid during a hold-off.
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= hold_off || (!quiet_mode && $urandom_range(99) < 12);
  end

  // Watchdog: count cycles with no handshake on either side.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Extremes: first allocate, return range edges, empty trim, unknown op.
  task automatic test_directed();
    send_op(OP_TRIM, 0, 0);
    send_op(OP_NONE, 63, 31);
    send_op(OP_RETURN, 0, 0);
    send_op(OP_ALLOC, 0, 0);
    send_op(OP_ALLOC, 63, 31);
    send_op(OP_RETURN, 63, 31);
    send_op(OP_RETURN, 0, 31);
    send_op(OP_RETURN, 0, 0);
    send_op(OP_RETURN, 0, 0);
    send_op(OP_NONE, 0, 0);
    send_op(OP_TRIM, 0, 0);
    held_slots.delete();
  endtask

  // Fill a slab so the hint runs dry and the forward rescan kicks in.
  task automatic test_slab_exhaust();
    repeat (70) send_op(OP_ALLOC, 0, 0);
    repeat (40) return_held();
    send_op(OP_TRIM, 0, 0);
  endtask

  // Open every frame, hit allocate-when-full, then reuse one returned slot.
  task automatic test_all_frames();
    while (shadow_live < NUM_FRAMES || shadow_hint_ok) send_op(OP_ALLOC, 0, 0);
    send_op(OP_ALLOC, 0, 0);
    send_op(OP_ALLOC, 0, 0);
    send_op(OP_RETURN, 63, 0);
    send_op(OP_ALLOC, 0, 0);
    send_op(OP_TRIM, 0, 0);
  endtask

  // Receiver holds off while the sender keeps offering items.
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      repeat (20) send_op(OP_ALLOC, 0, 0);
    join
  endtask

  // Mostly well-formed alloc/return traffic, some trims and noise.
  task automatic test_random(input int count, input bit no_idle);
    int pick;
    quiet_mode = no_idle;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 50) send_op(OP_ALLOC, $urandom_range(63), $urandom_range(31));
      else if (pick < 88) return_held();
      else if (pick < 93) send_op(OP_TRIM, $urandom_range(63), $urandom_range(31));
      else if (pick < 98) send_op(OP_RETURN, $urandom_range(63), $urandom_range(31));
      else send_op(OP_NONE, $urandom_range(63), $urandom_range(31));
      if (pick >= 88 && pick < 93) trims_seen++;
    end
    quiet_mode = 1'b0;
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_item    = '0;
    hold_off   = 1'b0;
    quiet_mode = 1'b0;
    error_count = 0;
    items_sent = 0;
    items_checked = 0;
    alloc_full_seen = 0;
    trims_seen = 0;
    idle_cycles = 0;
    for (int f = 0; f < NUM_FRAMES; f++) begin
      shadow_busy[f]  = 1'b0;
      shadow_count[f] = 0;
      shadow_l2f[f]   = 0;
      shadow_f2l[f]   = 0;
    end
    shadow_live    = 0;
    shadow_hint_ok = 1'b0;
    shadow_hint    = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_slab_exhaust();
    test_all_frames();
    test_backpressure();
    test_random(50, 1'b0);
    test_random(60, 1'b1);
    test_random(40, 1'b0);
    send_op(OP_TRIM, 0, 0);

    wait_drained();
    $display("Covered %0d items (%0d checked): alloc, return, trim, full-table allocates %0d,",
             items_sent, items_checked, alloc_full_seen);
    $display("random trims %0d, long receiver hold-off and idle-free stretch.", trims_seen);
    if (error_count == 0 && expected_items.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
